[rtl/core/lmfs_pkg.sv]
`default_nettype none

package lmfs_pkg;

  // Default geometry of the streak store.
  localparam int DEF_SLOTS    = 4;
  localparam int DEF_CHANNELS = 16;

  // Fixed widths of the transaction fields and of the display.
  localparam int POS_W    = 5;
  localparam int ROW_W    = 4;
  localparam int COLS_OUT = 16;
  localparam int CFG_W    = 5;

  // Last scan row before the row counter wraps.
  localparam logic [ROW_W-1:0] LAST_ROW = 4'd15;

  // Reset values of the configuration registers.
  localparam logic             RUN_ENABLE_RST = 1'b1;
  localparam logic [CFG_W-1:0] TAIL_LIMIT_RST = 5'd16;

  // Configuration register indexes.
  localparam logic REG_RUN_ENABLE = 1'b0;
  localparam logic REG_TAIL_LIMIT = 1'b1;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_SPAWN   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_RENDER  = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SPAWN_RD,
    ST_SPAWN_WR,
    ST_ADV_RD,
    ST_ADV_WR,
    ST_RND_RD,
    ST_RND_CHK,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming transaction
    logic rd;        // issue a read of the current column
    logic spawn_wr;  // write back the spawn update
    logic adv_wr;    // write back the advance update
    logic rnd_acc;   // merge the lit flag of the current column
    logic cnt_inc;   // step to the next column
    logic load_out;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic run_en;
    logic chan_ok;
    logic last_adv;
    logic last_rnd;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/lmfs_ram.sv]
`default_nettype none

module lmfs_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/lmfs_ctrl.sv]
`default_nettype none

module lmfs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lmfs_pkg::sts_t sts,
  output lmfs_pkg::cmd_t     cmd
);

  import lmfs_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.op == OP_SPAWN && sts.run_en && sts.chan_ok) begin
          state_next = ST_SPAWN_RD;
        end else if (sts.op == OP_ADVANCE && sts.run_en) begin
          state_next = ST_ADV_RD;
        end else if (sts.op == OP_RENDER) begin
          state_next = ST_RND_RD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SPAWN_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_SPAWN_WR;
      end
      ST_SPAWN_WR: begin
        cmd.spawn_wr = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_ADV_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_ADV_WR;
      end
      ST_ADV_WR: begin
        cmd.adv_wr = 1'b1;
        if (sts.last_adv) begin
          state_next = ST_FINISH;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = ST_ADV_RD;
        end
      end
      ST_RND_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_RND_CHK;
      end
      ST_RND_CHK: begin
        cmd.rnd_acc = 1'b1;
        if (sts.last_rnd) begin
          state_next = ST_FINISH;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = ST_RND_RD;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/lmfs_dp.sv]
`default_nettype none

module lmfs_dp #(
  parameter int SLOTS    = lmfs_pkg::DEF_SLOTS,
  parameter int CHANNELS = lmfs_pkg::DEF_CHANNELS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [1:0]                    opcode,
  input  wire logic [3:0]                    channel,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [lmfs_pkg::CFG_W-1:0]    cfg_data,
  input  wire lmfs_pkg::cmd_t                cmd,
  output lmfs_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lmfs_pkg::COLS_OUT-1:0]      row_bits,
  output logic [lmfs_pkg::ROW_W-1:0]         row_index,
  output logic                               frame_end,
  output logic                               spawn_done
);

  import lmfs_pkg::*;

  localparam int CHAN_W      = $clog2(CHANNELS);
  localparam int WORD_W      = SLOTS * POS_W;
  localparam int RENDER_COLS = (CHANNELS < COLS_OUT) ? CHANNELS : COLS_OUT;

  // Configuration registers.
  logic             run_en;
  logic [CFG_W-1:0] tail_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_en     <= RUN_ENABLE_RST;
      tail_limit <= TAIL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RUN_ENABLE: run_en     <= cfg_data[0];
        REG_TAIL_LIMIT: tail_limit <= cfg_data;
        default:        run_en     <= run_en;
      endcase
    end
  end

  // Latched transaction and per-item work registers.
  op_t                 op_q;
  logic [3:0]          chan_q;
  logic [CHAN_W-1:0]   cnt;
  logic [COLS_OUT-1:0] acc;
  logic                found_q;
  logic [ROW_W-1:0]    row_q;

  // Column store: one word per column, with a valid bit per column so that
  // an unwritten column reads as all slots empty.
  logic [CHAN_W-1:0]   addr;
  logic                mem_we;
  logic [WORD_W-1:0]   mem_wdata;
  logic [WORD_W-1:0]   mem_rdata;
  logic [CHANNELS-1:0] col_vld;
  logic                rd_vld;
  logic [WORD_W-1:0]   word;

  assign addr = (op_q == OP_SPAWN) ? CHAN_W'(chan_q) : cnt;

  lmfs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr),
    .wdata (mem_wdata),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (mem_we) begin
        col_vld[addr] <= 1'b1;
      end
      if (cmd.rd) begin
        rd_vld <= col_vld[addr];
      end
    end
  end

  assign word = rd_vld ? mem_rdata : '0;

  // Per-slot update logic for spawn, advance and render.
  logic [WORD_W-1:0] spawn_word;
  logic [WORD_W-1:0] adv_word;
  logic              free_found;
  logic              lit;
  logic [POS_W:0]    limit;
  logic [POS_W-1:0]  r0;
  logic [POS_W-1:0]  r1;
  logic [POS_W-1:0]  r2;

  assign limit = {1'b0, tail_limit} + (POS_W+1)'(3);
  assign r0    = {1'b0, row_q};
  assign r1    = r0 + POS_W'(1);
  assign r2    = r0 + POS_W'(2);

  always_comb begin
    logic [POS_W-1:0] p;
    spawn_word = word;
    adv_word   = '0;
    free_found = 1'b0;
    lit        = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      p = word[s*POS_W +: POS_W];
      // The lowest empty slot takes a new streak head.
      if (p == '0 && !free_found) begin
        spawn_word[s*POS_W +: POS_W] = POS_W'(1);
        free_found                   = 1'b1;
      end
      // A live streak steps down until it reaches the limit, then it is cleared.
      if (p != '0 && {1'b0, p} < limit) begin
        adv_word[s*POS_W +: POS_W] = p + POS_W'(1);
      end
      // A streak lights its head row and the two rows above it.
      if (p != '0 && (p == r0 || p == r1 || p == r2)) begin
        lit = 1'b1;
      end
    end
  end

  assign mem_we    = cmd.adv_wr || (cmd.spawn_wr && free_found);
  assign mem_wdata = cmd.spawn_wr ? spawn_word : adv_word;

  // Transaction capture, column counter and render accumulation.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op_t'(opcode);
      chan_q  <= channel;
      cnt     <= '0;
      acc     <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt <= cnt + CHAN_W'(1);
      end
      if (cmd.rnd_acc && lit) begin
        acc <= acc | (COLS_OUT'(1) << cnt);
      end
      if (cmd.spawn_wr) begin
        found_q <= free_found;
      end
    end
  end

  // Scan row counter, stepped by each render.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_q <= '0;
    end else if (cmd.load_out && op_q == OP_RENDER) begin
      row_q <= (row_q == LAST_ROW) ? '0 : row_q + ROW_W'(1);
    end
  end

  // Result register, freed when the receiver takes the transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (op_q == OP_RENDER) begin
        row_bits   <= acc;
        row_index  <= row_q;
        frame_end  <= (row_q == LAST_ROW);
        spawn_done <= 1'b0;
      end else if (op_q == OP_SPAWN) begin
        row_bits   <= '0;
        row_index  <= '0;
        frame_end  <= 1'b0;
        spawn_done <= found_q;
      end else begin
        row_bits   <= '0;
        row_index  <= '0;
        frame_end  <= 1'b0;
        spawn_done <= 1'b0;
      end
    end
  end

  // Status toward the controller.
  assign sts.op       = op_q;
  assign sts.run_en   = run_en;
  assign sts.chan_ok  = (32'(chan_q) < CHANNELS);
  assign sts.last_adv = (cnt == CHAN_W'(CHANNELS - 1));
  assign sts.last_rnd = (cnt == CHAN_W'(RENDER_COLS - 1));
  assign sts.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

[rtl/core/led_matrix_falling_streak_engine_core.sv]
// Falling-streak animation engine for a 16-column LED matrix.
// Input channel (in_valid/in_ready) carries one transaction per command:
// opcode spawns a streak in a column, advances all streaks one row, or
// renders the current scan row. Each transaction gives exactly one result
// on the output channel (out_valid/out_ready): the lit columns, the rendered
// row index and frame-end flag for a render, and spawn_done for a spawn.
// Work: a spawn reads and writes back its column, an advance reads and
// writes back every column, and a render reads and checks each of the
// first min(CHANNELS,16) columns; opcode 3 and commands blocked by a cleared
// run_enable skip the column store. The column store holds one word per
// column. One command is processed at a time; in_ready returns the cycle
// after the result is loaded. Configuration writes (cfg_we) take effect at
// once; the user must make them while the engine is idle, as the block
// itself does not enforce it.
// Reset empties all streaks at once through per-column valid bits, sets the
// row counter to 0, run_enable to 1 and tail_limit to 16. When the receiver
// stalls, the result is held and the following command waits after its work
// until the output register is free.
`default_nettype none

module led_matrix_falling_streak_engine_core #(
  parameter int SLOTS    = lmfs_pkg::DEF_SLOTS,
  parameter int CHANNELS = lmfs_pkg::DEF_CHANNELS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 opcode,
  input  wire logic [3:0]                 channel,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [lmfs_pkg::COLS_OUT-1:0]   row_bits,
  output logic [lmfs_pkg::ROW_W-1:0]      row_index,
  output logic                            frame_end,
  output logic                            spawn_done,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [lmfs_pkg::CFG_W-1:0] cfg_data
);

  import lmfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  lmfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Column store, update logic and result register.
  lmfs_dp #(
    .SLOTS    (SLOTS),
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .opcode     (opcode),
    .channel    (channel),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_bits   (row_bits),
    .row_index  (row_index),
    .frame_end  (frame_end),
    .spawn_done (spawn_done)
  );

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmfs_pkg::*;

  localparam int SLOTS         = DEF_SLOTS;
  localparam int CHANNELS      = DEF_CHANNELS;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // Long enough for the longest command, which visits every column, with slack.
  localparam int SETTLE_CYCLES = 2 * CHANNELS + 8;

  // One result transaction as it leaves the engine.
  typedef struct packed {
    logic [COLS_OUT-1:0] row_bits;
    logic [ROW_W-1:0]    row_index;
    logic                frame_end;
    logic                spawn_done;
  } row_result_t;

  // Tracks the streak store and scan row, and checks every result in order.
  class streak_scoreboard;
    logic [POS_W-1:0] head_pos[CHANNELS * SLOTS];
    logic [ROW_W-1:0] scan_row;
    logic             run_en;
    logic [CFG_W-1:0] tail_lim;
    row_result_t      pending_results[$];
    int               mismatches;

    function new();
      foreach (head_pos[i]) head_pos[i] = '0;
      scan_row   = '0;
      run_en     = RUN_ENABLE_RST;
      tail_lim   = TAIL_LIMIT_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] data);
      if (idx == REG_RUN_ENABLE) begin
        run_en = data[0];
      end else begin
        tail_lim = data;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Apply one accepted command to the streak store and queue its result.
    function void note_command(op_t op, logic [3:0] chan);
      row_result_t res;
      int          base;
      int          lim;
      int          p;
      int          r;
      res = '0;
      case (op)
        OP_SPAWN: begin
          if (run_en && int'(chan) < CHANNELS) begin
            base = int'(chan) * SLOTS;
            for (int s = 0; s < SLOTS; s++) begin
              if (head_pos[base + s] == '0) begin
                head_pos[base + s] = POS_W'(1);
                res.spawn_done     = 1'b1;
                break;
              end
            end
          end
        end
        OP_ADVANCE: begin
          if (run_en) begin
            lim = int'(tail_lim) + 3;
            foreach (head_pos[i]) begin
              p = int'(head_pos[i]);
              if (p > 0 && p < lim) begin
                head_pos[i] = head_pos[i] + 1'b1;
              end else begin
                head_pos[i] = '0;
              end
            end
          end
        end
        OP_RENDER: begin
          r = int'(scan_row);
          for (int c = 0; c < CHANNELS && c < COLS_OUT; c++) begin
            for (int s = 0; s < SLOTS; s++) begin
              p = int'(head_pos[c * SLOTS + s]);
              // An empty slot never lights its column, even on row 0.
              if (p != 0 && p >= r && p <= r + 2) res.row_bits[c] = 1'b1;
            end
          end
          res.row_index = scan_row;
          res.frame_end = (scan_row == LAST_ROW);
          scan_row      = scan_row + 1'b1;
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(row_result_t got);
      row_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: bits=%h row=%0d frame_end=%b spawn_done=%b",
                   got.row_bits, got.row_index, got.frame_end, got.spawn_done);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch at %0t: bits exp %h got %h, row exp %0d got %0d,",
                     $realtime, want.row_bits, got.row_bits, want.row_index,
                     got.row_index);
            $display("  frame_end exp %b got %b, spawn_done exp %b got %b",
                     want.frame_end, got.frame_end, want.spawn_done, got.spawn_done);
          end
        end
      end
    endfunction
  endclass

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             in_valid   = 1'b0;
  logic             in_ready;
  logic [1:0]       opcode     = OP_NOP;
  logic [3:0]       channel    = '0;
  logic             out_valid;
  logic             out_ready  = 1'b0;
  logic [COLS_OUT-1:0] row_bits;
  logic [ROW_W-1:0] row_index;
  logic             frame_end;
  logic             spawn_done;
  logic             cfg_we     = 1'b0;
  logic             cfg_index  = REG_RUN_ENABLE;
  logic [CFG_W-1:0] cfg_data   = '0;

  // When set, neither side inserts idle cycles.
  bit               steady     = 1'b0;
  int               cycle_count = 0;

  streak_scoreboard results = new();

  led_matrix_falling_streak_engine_core #(
    .SLOTS(SLOTS),
    .CHANNELS(CHANNELS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .channel(channel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .row_bits(row_bits),
    .row_index(row_index),
    .frame_end(frame_end),
    .spawn_done(spawn_done),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one command and hold it until the engine takes it.
  task automatic send_command(op_t op, logic [3:0] chan);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    opcode   = op;
    channel  = chan;
    do @(posedge clk); while (!in_ready);
    results.note_command(op, chan);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (results.pending() > 0) @(posedge clk);
  endtask

  // Registers change only while the engine holds no command.
  task automatic program_reg(logic idx, logic [CFG_W-1:0] data);
    wait_drained();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    results.write_reg(idx, data);
  endtask

  // One animation step: a few spawns, an advance, then a run of scan rows.
  task automatic run_frame(input int max_renders, output int n);
    int spawns;
    int renders;
    spawns  = $urandom_range(0, 3);
    renders = $urandom_range(0, max_renders);
    repeat (spawns) send_command(OP_SPAWN, 4'($urandom_range(0, 15)));
    send_command(OP_ADVANCE, 4'($urandom_range(0, 15)));
    repeat (renders) send_command(OP_RENDER, 4'($urandom_range(0, 15)));
    n = spawns + 1 + renders;
  endtask

  // Receiver side: random stalls, none while steady.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_ready  = 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 99) < 35) stall_left = pick_gap();
      end
    end
  end

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results.check_result({row_bits, row_index, frame_end, spawn_done});
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int          tail;
    logic        run_bit;
    int          max_renders;
    int          items;
    int          sent;
    int          n;
    int          drain_at;
    bit          drained;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty matrix, full column, both channel extremes, no-op.
    send_command(OP_RENDER, 4'h0);
    repeat (5) send_command(OP_SPAWN, 4'h0);
    send_command(OP_SPAWN, 4'hF);
    send_command(OP_RENDER, 4'h5);
    send_command(OP_NOP, 4'hA);
    send_command(OP_ADVANCE, 4'h5);
    send_command(OP_RENDER, 4'h0);

    // Run disabled: spawn and advance do nothing, render still scans.
    program_reg(REG_RUN_ENABLE, 5'b11110);
    send_command(OP_SPAWN, 4'h3);
    send_command(OP_ADVANCE, 4'hC);
    send_command(OP_RENDER, 4'h3);
    send_command(OP_NOP, 4'hF);
    program_reg(REG_RUN_ENABLE, 5'b10101);

    // Zero tail limit: streaks die after reaching position three.
    program_reg(REG_TAIL_LIMIT, 5'd0);
    send_command(OP_ADVANCE, 4'h0);
    send_command(OP_ADVANCE, 4'hF);
    send_command(OP_RENDER, 4'h0);
    send_command(OP_RENDER, 4'h0);

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin tail = 16; run_bit = 1'b1; max_renders = 16; items = 200; end
        1: begin tail = 1;  run_bit = 1'b1; max_renders = 16; items = 150; end
        2: begin tail = 31; run_bit = 1'b1; max_renders = 2;  items = 200; end
        3: begin tail = 0;  run_bit = 1'b1; max_renders = 8;  items = 100; end
        4: begin
          tail = $urandom_range(1, 16); run_bit = 1'b0; max_renders = 16; items = 60;
        end
        default: begin
          tail        = $urandom_range(1, 16);
          run_bit     = ($urandom_range(0, 9) != 0);
          max_renders = $urandom_range(2, 16);
          items       = 150;
        end
      endcase
      program_reg(REG_TAIL_LIMIT, 5'(tail));
      program_reg(REG_RUN_ENABLE, {4'($urandom_range(0, 15)), run_bit});
      steady   = (ph == 1);
      sent     = 0;
      drained  = 1'b0;
      drain_at = $urandom_range(0, items - 1);
      while (sent < items) begin
        if ($urandom_range(0, 99) < 70) begin
          run_frame(max_renders, n);
          sent += n;
        end else begin
          send_command(op_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
          sent++;
        end
        // Hold the sender once per phase until the engine has emptied.
        if (!drained && sent >= drain_at) begin
          wait_drained();
          drained = 1'b1;
        end
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results.mismatches == 0 && results.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/core/lmfs_pkg.sv
rtl/core/lmfs_ram.sv
rtl/core/lmfs_ctrl.sv
rtl/core/lmfs_dp.sv
rtl/core/led_matrix_falling_streak_engine_core.sv
verif/tb.sv
